// ===== hw/rtl/cgf_pkg.sv =====
// Shared types and constants of the causal Gaussian FIR smoother.
`default_nettype none

package cgf_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int WEIGHT_REGS = 8;
    localparam int FRAC_BITS   = 15;
    localparam int PROD_W      = SAMPLE_BITS + WEIGHT_BITS;
    localparam int PADDR_W     = $clog2(WEIGHT_REGS * 4);
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = $clog2(WEIGHT_REGS);

    localparam logic [REG_IDX_W-1:0] REG_TAP_WEIGHT_0 = REG_IDX_W'(0);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(32768);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] t_sample_arr;
    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [WEIGHT_REGS-1:0][WEIGHT_BITS-1:0] t_weight_arr;

    // Stage enables handed from the pipeline control to the lanes and the output stage.
    typedef struct packed {
        logic shift;
        logic en_prod;
        logic en_sum;
        logic en_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/cgf_if.sv =====
// Word channels of the smoother: sample words in, smoothed words out.
`default_nettype none

interface cgf_smp_if;
    logic                 valid;
    logic                 ready;
    cgf_pkg::t_sample     sample_0;
    cgf_pkg::t_sample     sample_1;
    cgf_pkg::t_sample     sample_2;
    cgf_pkg::t_sample     sample_3;

    modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
    modport sink   (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

interface cgf_res_if;
    logic                 valid;
    logic                 ready;
    cgf_pkg::t_sample     smoothed_0;
    cgf_pkg::t_sample     smoothed_1;
    cgf_pkg::t_sample     smoothed_2;
    cgf_pkg::t_sample     smoothed_3;

    modport source (output valid, smoothed_0, smoothed_1, smoothed_2, smoothed_3, input ready);
    modport sink   (input valid, smoothed_0, smoothed_1, smoothed_2, smoothed_3, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cgf_regs.sv =====
// APB register file holding the tap weights.
`default_nettype none

module cgf_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [cgf_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [cgf_pkg::PDATA_W-1:0]     pwdata,
    output logic      [cgf_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready,
    output cgf_pkg::t_weight_arr                 o_weight
);

    cgf_pkg::t_weight_arr                r_weight;
    logic [cgf_pkg::REG_IDX_W-1:0]       w_idx;
    logic                                w_wr;

    assign w_idx  = paddr[cgf_pkg::PADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // Reset leaves unity weight on the newest tap and zero everywhere else.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < cgf_pkg::WEIGHT_REGS; k++) begin
                r_weight[k] <= (k == int'(cgf_pkg::REG_TAP_WEIGHT_0)) ?
                               cgf_pkg::WEIGHT_ONE : '0;
            end
        end else if (w_wr) begin
            r_weight[w_idx] <= pwdata[cgf_pkg::WEIGHT_BITS-1:0];
        end
    end

    assign prdata   = cgf_pkg::PDATA_W'(r_weight[w_idx]);
    assign o_weight = r_weight;

endmodule

`default_nettype wire

// ===== hw/rtl/cgf_lane.sv =====
// One channel lane: history line, registered tap products and registered tap sum.
`default_nettype none

module cgf_lane #(
    parameter int TAPS = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire cgf_pkg::t_pipe_ctl          i_ctl,
    input  wire cgf_pkg::t_sample            i_sample,
    input  wire cgf_pkg::t_weight_arr        i_weight,
    output logic signed [cgf_pkg::PROD_W+$clog2(TAPS)-1:0] o_sum
);

    localparam int PROD_W = cgf_pkg::PROD_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    cgf_pkg::t_sample           r_hist [TAPS];
    logic signed [PROD_W-1:0]   r_prod [TAPS];
    logic signed [PROD_W-1:0]   n_prod [TAPS];
    logic signed [ACC_W-1:0]    r_sum;
    logic signed [ACC_W-1:0]    n_sum;

    // The newest sample sits in entry zero; reset leaves zeros behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_hist[k] <= '0;
            end
        end else if (i_ctl.shift) begin
            r_hist[0] <= i_sample;
            for (int k = 1; k < TAPS; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // One multiplier per tap, all side by side. A signed sample times an unsigned
    // 16-bit weight always fits in PROD_W signed bits.
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            n_prod[k] = r_hist[k] * $signed({1'b0, i_weight[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_prod) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= n_prod[k];
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_sum = n_sum + ACC_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== hw/rtl/cgf_merge.sv =====
// Output stage: rounds and saturates every lane sum into the output word register.
`default_nettype none

module cgf_merge #(
    parameter int TAPS = 8
) (
    input  wire logic                     i_clk,
    input  wire cgf_pkg::t_pipe_ctl       i_ctl,
    input  wire logic [cgf_pkg::CHANNELS-1:0][cgf_pkg::PROD_W+$clog2(TAPS)-1:0] i_sum,
    output cgf_pkg::t_sample_arr          o_smoothed
);

    localparam int ACC_W = cgf_pkg::PROD_W + $clog2(TAPS);
    localparam int Q_W   = ACC_W + 1 - cgf_pkg::FRAC_BITS;
    localparam int SB    = cgf_pkg::SAMPLE_BITS;
    localparam logic signed [ACC_W:0] ROUND_HALF =
        (ACC_W+1)'(1) <<< (cgf_pkg::FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((1 << (SB - 1)) - 1);
    localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

    cgf_pkg::t_sample_arr        r_out;
    cgf_pkg::t_sample_arr        n_out;
    logic signed [ACC_W:0]       w_biased [cgf_pkg::CHANNELS];
    logic signed [ACC_W:0]       w_shift  [cgf_pkg::CHANNELS];
    logic signed [Q_W-1:0]       w_q      [cgf_pkg::CHANNELS];

    // Round half up: add one half, then an arithmetic shift floors the quotient.
    always_comb begin
        for (int c = 0; c < cgf_pkg::CHANNELS; c++) begin
            w_biased[c] = $signed({i_sum[c][ACC_W-1], i_sum[c]}) + ROUND_HALF;
            w_shift[c]  = w_biased[c] >>> cgf_pkg::FRAC_BITS;
            w_q[c]      = w_shift[c][Q_W-1:0];
            if (w_q[c] > SAT_HI) begin
                n_out[c] = SAT_HI[SB-1:0];
            end else if (w_q[c] < SAT_LO) begin
                n_out[c] = SAT_LO[SB-1:0];
            end else begin
                n_out[c] = w_q[c][SB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_out) begin
            r_out <= n_out;
        end
    end

    assign o_smoothed = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/causal_gaussian_fir_multichannel_unit.sv =====
// Top level of the four-channel causal half-Gaussian FIR smoother.
`default_nettype none

// Each sample word carries one signed 16-bit sample per channel. Every channel
// shifts its sample into its own history of TAPS samples (zeros after reset)
// and delivers the weighted sum of that history, where tap_weight_k (unsigned
// Q1.15, written over APB at byte address 4*k) weighs the sample k words old.
// The sum is rounded half up to the sample scale and saturated to the signed
// 16-bit range. One smoothed word comes out for every sample word taken in.
// The block takes one word per clock cycle when the output side keeps up; a
// word passes in turn through the history update, the tap multipliers
// (one per tap in each channel lane), the tap adder, and the round-and-saturate
// output register. Each stage holds only while the stage after it is full, so
// a word waiting at the output does not stop new words from filling the empty
// stages behind it. Tap weights should be written only while no word is in
// flight; weights of taps at or beyond TAPS are stored and read back but not used.
module causal_gaussian_fir_multichannel_unit #(
    parameter int TAPS = 8
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    cgf_smp_if.sink                           i_smp,
    cgf_res_if.source                         o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [cgf_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cgf_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cgf_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready
);

    localparam int ACC_W = cgf_pkg::PROD_W + $clog2(TAPS);

    // Valid bits of the history, product and sum stages and of the output register.
    logic                   r_v_hist;
    logic                   r_v_prod;
    logic                   r_v_sum;
    logic                   r_v_out;
    logic                   w_en_hist;
    cgf_pkg::t_pipe_ctl     w_ctl;
    cgf_pkg::t_weight_arr   w_weight;
    cgf_pkg::t_sample_arr   w_samples;
    cgf_pkg::t_sample_arr   w_smoothed;
    logic [cgf_pkg::CHANNELS-1:0][ACC_W-1:0] w_sum;

    // A stage loads when it is empty or when the stage after it loads.
    assign w_ctl.en_out  = !r_v_out  || o_res.ready;
    assign w_ctl.en_sum  = !r_v_sum  || w_ctl.en_out;
    assign w_ctl.en_prod = !r_v_prod || w_ctl.en_sum;
    assign w_en_hist     = !r_v_hist || w_ctl.en_prod;
    assign w_ctl.shift   = i_smp.valid && w_en_hist;
    assign i_smp.ready   = w_en_hist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_hist <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_en_hist) begin
                r_v_hist <= i_smp.valid;
            end
            if (w_ctl.en_prod) begin
                r_v_prod <= r_v_hist;
            end
            if (w_ctl.en_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (w_ctl.en_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    assign w_samples[0] = i_smp.sample_0;
    assign w_samples[1] = i_smp.sample_1;
    assign w_samples[2] = i_smp.sample_2;
    assign w_samples[3] = i_smp.sample_3;

    cgf_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_weight (w_weight)
    );

    // One lane per channel, all running in lockstep.
    for (genvar c = 0; c < cgf_pkg::CHANNELS; c++) begin : g_lane
        cgf_lane #(
            .TAPS (TAPS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_sample ($signed(w_samples[c])),
            .i_weight (w_weight),
            .o_sum    (w_sum[c])
        );
    end

    cgf_merge #(
        .TAPS (TAPS)
    ) u_merge (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_sum      (w_sum),
        .o_smoothed (w_smoothed)
    );

    assign o_res.valid      = r_v_out;
    assign o_res.smoothed_0 = w_smoothed[0];
    assign o_res.smoothed_1 = w_smoothed[1];
    assign o_res.smoothed_2 = w_smoothed[2];
    assign o_res.smoothed_3 = w_smoothed[3];

endmodule

`default_nettype wire

// ===== hw/rtl/cgf_checker.sv =====
// Port-level checker of the smoother and its bind to the top level.
`default_nettype none

module cgf_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_out_data
);

    localparam int DEPTH = 4;

    logic [2:0] r_cnt;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // Words taken in and not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 3'(w_in_acc) - 3'(w_out_acc);
        end
    end

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_no_invented_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 3'd0)
        else $error("output word without a matching input word");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(DEPTH))
        else $error("more words in flight than pipeline stages");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled while the output side is free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");

endmodule

bind causal_gaussian_fir_multichannel_unit cgf_checker u_cgf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  ({o_res.smoothed_3, o_res.smoothed_2, o_res.smoothed_1, o_res.smoothed_0})
);

`default_nettype wire

// ===== tb/sv/tb_causal_gaussian_fir_multichannel_unit.sv =====
// Self-checking testbench of the four-channel causal half-Gaussian FIR smoother.
`timescale 1ns / 1ps

module tb_causal_gaussian_fir_multichannel_unit;

    import cgf_pkg::*;

    localparam int  TAPS         = 8;
    localparam int  ITEMS_PER_SET = 95;   // random sample words per weight setting
    localparam int  WEIGHT_SETS  = 10;    // random weight settings
    localparam int  SETTLE_CYCLES = 8;    // settle wait after draining; pipeline is four deep
    localparam int  HOLD_CYCLES  = 400;   // long output stall that fills the pipeline
    localparam int  STALL_LIMIT  = 3000;  // cycles with no word moving before giving up
    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);

    // Which side leaves gaps in its handshake, per stimulus stretch.
    typedef enum {
        SENDER_LIGHT_IDLE,   // sender idles with a 25 percent chance, receiver 70
        SENDER_HEAVY_IDLE,   // sender idles with a 70 percent chance, receiver 25
        NO_IDLE
    } t_idle_mode;

    // Shapes of the tap weight set loaded for one stretch of random words.
    typedef enum {
        WEIGHTS_ZERO,
        WEIGHTS_ALL_ONE,
        WEIGHTS_ALL_MAX,
        WEIGHTS_RANDOM_Q15,
        WEIGHTS_RANDOM_FULL,
        WEIGHTS_HALF_GAUSS
    } t_weight_kind;

    logic i_clk;
    logic i_rst_n = 1'b0;

    // Sample word source and smoothed word sink, both owned by the testbench.
    logic        drv_valid = 1'b0;
    t_sample_arr drv_word  = '0;
    logic        rcv_ready = 1'b0;

    // APB master signals.
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    cgf_smp_if smp_if();
    cgf_res_if res_if();

    assign smp_if.valid    = drv_valid;
    assign smp_if.sample_0 = drv_word[0];
    assign smp_if.sample_1 = drv_word[1];
    assign smp_if.sample_2 = drv_word[2];
    assign smp_if.sample_3 = drv_word[3];
    assign res_if.ready    = rcv_ready;

    causal_gaussian_fir_multichannel_unit #(
        .TAPS(TAPS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Sample words waiting to be offered, and smoothed words the block owes us.
    t_sample_arr sample_words_q[$];
    t_sample_arr smoothed_q[$];

    // Shadow of the tap weight registers and of every channel's history line.
    t_weight_arr tap_weights;
    t_sample     history [CHANNELS][TAPS];

    t_idle_mode idle_mode     = SENDER_LIGHT_IDLE;
    int         mismatch_count = 0;
    int         hold_requests  = 0;
    int         holds_granted  = 0;
    int         hold_left      = 0;
    int         quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every mismatch goes through here: one line printed and one more counted.
    task automatic flag_mismatch(input string what);
        $display("[%0t] smoothed word error: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Append a sample word to the stimulus queue.
    task automatic queue_word(input t_sample_arr word);
        sample_words_q.insert(sample_words_q.size(), word);
    endtask

    // Shift one sample word into the history lines and return the smoothed word that
    // the block must produce for it. Each channel is the Q1.15 weighted sum of its
    // newest TAPS samples, rounded half up (add half an LSB, then floor) and clamped.
    function automatic t_sample_arr filter_word(input t_sample_arr word);
        t_sample_arr smoothed;
        longint      acc;
        longint      q;
        for (int c = 0; c < CHANNELS; c++) begin
            for (int k = TAPS - 1; k > 0; k--)
                history[c][k] = history[c][k-1];
            history[c][0] = t_sample'(word[c]);
            acc = 0;
            for (int k = 0; k < TAPS && k < WEIGHT_REGS; k++)
                acc += longint'(history[c][k]) * longint'(tap_weights[k]);
            // The shift is arithmetic on a signed longint, so it floors.
            q = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (q > SAMPLE_MAX)
                q = SAMPLE_MAX;
            else if (q < SAMPLE_MIN)
                q = SAMPLE_MIN;
            smoothed[c] = q[SAMPLE_BITS-1:0];
        end
        return smoothed;
    endfunction

    function automatic bit sender_skips();
        case (idle_mode)
            SENDER_LIGHT_IDLE: return $urandom_range(99) < 25;
            SENDER_HEAVY_IDLE: return $urandom_range(99) < 70;
            default:           return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_skips();
        case (idle_mode)
            SENDER_LIGHT_IDLE: return $urandom_range(99) < 70;
            SENDER_HEAVY_IDLE: return $urandom_range(99) < 25;
            default:           return 1'b0;
        endcase
    endfunction

    // Driver: keeps a word on the bus until the block takes it, predicts the result
    // at the edge of acceptance, and then decides whether to offer the next word or
    // leave a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && smp_if.ready)
                smoothed_q.insert(smoothed_q.size(), filter_word(drv_word));
            if (!drv_valid || smp_if.ready) begin
                if (sample_words_q.size() != 0 && !sender_skips()) begin
                    drv_word  <= sample_words_q[0];
                    drv_valid <= 1'b1;
                    sample_words_q.delete(0);
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Long output hold-off. The stimulus asks for one by bumping hold_requests; this
    // process counts it out so the sink stays quiet while the source keeps pushing.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left     <= 0;
            holds_granted <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_granted != hold_requests) begin
            hold_left     <= HOLD_CYCLES;
            holds_granted <= holds_granted + 1;
        end
    end

    // Monitor: every smoothed word taken is checked channel by channel against the
    // oldest prediction; then ready is chosen for the next cycle.
    always @(posedge i_clk) begin
        t_sample_arr got;
        t_sample_arr want;
        if (!i_rst_n) begin
            rcv_ready <= 1'b0;
        end else begin
            if (res_if.valid && rcv_ready) begin
                got = {res_if.smoothed_3, res_if.smoothed_2,
                       res_if.smoothed_1, res_if.smoothed_0};
                if (smoothed_q.size() == 0) begin
                    flag_mismatch($sformatf("word %h arrived with none outstanding", got));
                end else begin
                    want = smoothed_q[0];
                    smoothed_q.delete(0);
                    for (int c = 0; c < CHANNELS; c++)
                        if (got[c] !== want[c])
                            flag_mismatch($sformatf("channel %0d got %0d, want %0d",
                                                    c, $signed(got[c]), $signed(want[c])));
                end
            end
            rcv_ready <= (hold_left == 0) && !receiver_skips();
        end
    end

    // Watchdog: a run in which no word moves on either side for too long is hung.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((drv_valid && smp_if.ready) || (res_if.valid && rcv_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Wait until every offered word was taken and every smoothed word came back, then
    // wait out the settle time as well so the pipeline is truly empty.
    task automatic wait_idle();
        while (sample_words_q.size() != 0 || drv_valid || smoothed_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input int index, input t_weight value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(index * 4);
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tap_weights[index] = value;
    endtask

    // Load all eight weight registers; only called with the pipeline drained.
    task automatic load_weights(input t_weight_arr weights);
        wait_idle();
        for (int k = 0; k < WEIGHT_REGS; k++)
            apb_write(k, weights[k]);
    endtask

    function automatic t_weight_arr weight_pattern(input t_weight_kind kind);
        t_weight_arr w;
        case (kind)
            WEIGHTS_ZERO:    w = '0;
            WEIGHTS_ALL_ONE: for (int k = 0; k < WEIGHT_REGS; k++) w[k] = WEIGHT_ONE;
            WEIGHTS_ALL_MAX: for (int k = 0; k < WEIGHT_REGS; k++) w[k] = '1;
            WEIGHTS_RANDOM_Q15:
                for (int k = 0; k < WEIGHT_REGS; k++) w[k] = t_weight'($urandom_range(32768));
            WEIGHTS_RANDOM_FULL:
                for (int k = 0; k < WEIGHT_REGS; k++) w[k] = t_weight'($urandom);
            default: begin
                // A decaying tail, roughly what software derives from some sigma.
                w[0] = t_weight'($urandom_range(32768, 6000));
                for (int k = 1; k < WEIGHT_REGS; k++)
                    w[k] = t_weight'((int'(w[k-1]) * int'($urandom_range(95, 30))) / 100);
            end
        endcase
        return w;
    endfunction

    // Samples lean toward the rails and toward small values around zero, where
    // saturation and rounding show up; the rest are uniform over all 16 bits.
    function automatic t_sample_arr random_word();
        t_sample_arr word;
        for (int c = 0; c < CHANNELS; c++)
            case ($urandom_range(9))
                0:       word[c] = SAMPLE_BITS'(SAMPLE_MAX);
                1:       word[c] = SAMPLE_BITS'(SAMPLE_MIN);
                2:       word[c] = SAMPLE_BITS'(int'($urandom_range(15)) - 8);
                default: word[c] = SAMPLE_BITS'($urandom);
            endcase
        return word;
    endfunction

    function automatic t_sample_arr make_word(input int s0, input int s1,
                                              input int s2, input int s3);
        return {SAMPLE_BITS'(s3), SAMPLE_BITS'(s2), SAMPLE_BITS'(s1), SAMPLE_BITS'(s0)};
    endfunction

    initial begin
        t_weight_arr w;
        t_weight_kind kind;

        tap_weights    = '0;
        tap_weights[0] = WEIGHT_ONE;
        for (int c = 0; c < CHANNELS; c++)
            for (int k = 0; k < TAPS; k++)
                history[c][k] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // With the reset weights the block passes samples straight through; the very
        // first word after reset must come out, not be swallowed.
        idle_mode = SENDER_LIGHT_IDLE;
        queue_word(make_word(32767, -32768, 0, -1));
        queue_word(make_word(-32768, 32767, 1, 0));
        queue_word(make_word(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00));

        // Weights above 1.0 are used as they stand: sums run into both rails.
        load_weights('1);
        repeat (3) queue_word(make_word(32767, -32768, 32767, -32768));
        repeat (3) queue_word(make_word(-32768, 32767, -32768, 32767));

        // Half weight on the newest tap only: odd samples land exactly on the
        // rounding boundary, positive ones round up and negative ones toward zero.
        w    = '0;
        w[0] = t_weight'(16384);
        load_weights(w);
        queue_word(make_word(1, -1, 3, -3));
        queue_word(make_word(32767, -32768, 2, -2));
        queue_word(make_word(-32767, 32765, -5, 5));

        // A typical half-Gaussian kernel with a short run of arbitrary words.
        w = {16'd28, 16'd145, 16'd575, 16'd1773, 16'd4253, 16'd7946, 16'd11565, 16'd13107};
        load_weights(w);
        repeat (8) queue_word(random_word());

        // Random part. Each stretch loads a new weight set with the pipeline empty, so
        // the source also pauses until every smoothed word is back. The last stretch
        // carries the long output hold-off with the source offering every cycle.
        for (int set = 0; set < WEIGHT_SETS; set++) begin
            if (set < 4)
                idle_mode = SENDER_LIGHT_IDLE;
            else if (set < 8)
                idle_mode = SENDER_HEAVY_IDLE;
            else
                idle_mode = NO_IDLE;
            kind = t_weight_kind'(set % 6);
            load_weights(weight_pattern(kind));
            if (set == WEIGHT_SETS - 1)
                hold_requests++;
            repeat (ITEMS_PER_SET) queue_word(random_word());
        end

        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (smoothed_q.size() != 0)
            flag_mismatch($sformatf("%0d smoothed words never arrived", smoothed_q.size()));

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cgf_pkg.sv
hw/rtl/cgf_if.sv
hw/rtl/cgf_regs.sv
hw/rtl/cgf_lane.sv
hw/rtl/cgf_merge.sv
hw/rtl/causal_gaussian_fir_multichannel_unit.sv
hw/rtl/cgf_checker.sv
tb/sv/tb_causal_gaussian_fir_multichannel_unit.sv
